// File: sv/mlp_pkg.sv
// Shared constants, codes and types of the three-layer inference unit.
// Depends on nothing; used by the RAM wrapper users and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;
  localparam int MaxInputs  = 512;
  localparam int MaxHidden  = 256;
  localparam int MaxOutputs = 8;
  localparam int DataWidth  = 16;
  localparam int FracBits   = DataWidth / 2;
  localparam int AccWidth   = 40;
  localparam int ProdWidth  = 2 * DataWidth;

  localparam int W1Base = MaxInputs * MaxHidden;
  localparam int W2Base = W1Base + MaxHidden * MaxHidden;
  localparam int WDepth = W2Base + MaxOutputs * MaxHidden;
  localparam int BDepth = 2 * MaxHidden + MaxOutputs;

  localparam int WAW = $clog2(WDepth);
  localparam int BAW = $clog2(BDepth);
  localparam int IAW = $clog2(MaxInputs);
  localparam int HAW = $clog2(MaxHidden);
  localparam int ICW = $clog2(MaxInputs + 1);
  localparam int NCW = $clog2(MaxHidden + 1);
  localparam int OutCap = (MaxOutputs < 8) ? MaxOutputs : 8;

  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_INPUT  = 2'd2,
    FUNC_RUN    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_INPUT_SIZE = 2'd0,
    REG_HIDDEN_ONE = 2'd1,
    REG_HIDDEN_TWO = 2'd2,
    REG_OUTPUT_SIZE = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Tag that travels with each memory access down the datapath.
  typedef struct packed {
    logic           is_bias;
    logic           last;
    logic [1:0]     layer;
    logic [NCW-1:0] nrn;
  } tag_t;
endpackage
`default_nettype wire

// File: sv/mlp_forward_relu_unit.sv
// Top level of the three-layer Q8.8 inference unit: load, sequencing, MAC datapath.
// Depends on mlp_pkg and mlp_ram.
//
//  channel | signals                                   | direction
//  item    | start_i busy_o func_i layer_i row_i col_i value_i | in, busy_o out
//  result  | valid_o logit_index_o logit_value_o last_o | out
//  config  | psel penable pwrite paddr pwdata prdata pready | APB
//
// A load item is taken only while busy_o is low. A run issues one access per cycle:
// for each neuron a bias access, then one multiply-accumulate per input; it drains
// the pipeline after each layer. Reset idles control and sets the default sizes;
// memories hold nothing defined until loaded. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module mlp_forward_relu_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [1:0]  layer_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [8:0]  col_i,
  input  wire logic signed [15:0] value_i,
  output logic             valid_o,
  output logic [2:0]       logit_index_o,
  output logic signed [15:0] logit_value_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mlp_pkg::*;

  // Configuration registers.
  logic [9:0] in_size_q;
  logic [8:0] h1_size_q, h2_size_q;
  logic [3:0] out_size_q;
  logic       cfg_we;
  reg_e       cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= 10'd412;
      h1_size_q  <= 9'd256;
      h2_size_q  <= 9'd256;
      out_size_q <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_INPUT_SIZE:  in_size_q  <= pwdata[9:0];
        REG_HIDDEN_ONE:  h1_size_q  <= pwdata[8:0];
        REG_HIDDEN_TWO:  h2_size_q  <= pwdata[8:0];
        REG_OUTPUT_SIZE: out_size_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_INPUT_SIZE:  prdata = {22'd0, in_size_q};
      REG_HIDDEN_ONE:  prdata = {23'd0, h1_size_q};
      REG_HIDDEN_TWO:  prdata = {23'd0, h2_size_q};
      REG_OUTPUT_SIZE: prdata = {28'd0, out_size_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Clamped sizes.
  logic [ICW-1:0] ni;
  logic [NCW-1:0] n1, n2, n3;
  always_comb begin
    ni = (in_size_q == '0) ? ICW'(1) :
         ((int'(in_size_q) > MaxInputs) ? ICW'(MaxInputs) : ICW'(in_size_q));
    n1 = (h1_size_q == '0) ? NCW'(1) :
         ((int'(h1_size_q) > MaxHidden) ? NCW'(MaxHidden) : NCW'(h1_size_q));
    n2 = (h2_size_q == '0) ? NCW'(1) :
         ((int'(h2_size_q) > MaxHidden) ? NCW'(MaxHidden) : NCW'(h2_size_q));
    n3 = (out_size_q == '0) ? NCW'(1) :
         ((int'(out_size_q) > OutCap) ? NCW'(OutCap) : NCW'(out_size_q));
  end

  // Sequencer.
  state_e         state_q, state_d;
  logic [1:0]     lay_q, lay_d;
  logic [NCW-1:0] nrn_q, nrn_d;
  logic [ICW-1:0] idx_q, idx_d;
  logic           bph_q, bph_d;
  logic [ICW-1:0] nin;
  logic [NCW-1:0] nout;
  logic           accept, is_run, pipe_empty, issue;
  tag_t           iss_tag;

  tag_t s1_tag_q, s2_tag_q, f_tag_q;
  logic s1_v_q, s2_v_q, f_v_q;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i & ~busy_o;
  assign is_run     = (func_e'(func_i) == FUNC_RUN);
  assign pipe_empty = ~s1_v_q & ~s2_v_q & ~f_v_q;
  assign issue      = (state_q == ST_ISSUE);

  always_comb begin
    unique case (lay_q)
      2'd0:    begin nin = ni;           nout = n1; end
      2'd1:    begin nin = ICW'(n1);     nout = n2; end
      default: begin nin = ICW'(n2);     nout = n3; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    lay_d   = lay_q;
    nrn_d   = nrn_q;
    idx_d   = idx_q;
    bph_d   = bph_q;
    iss_tag.is_bias = bph_q;
    iss_tag.last    = ~bph_q & (idx_q == nin - ICW'(1));
    iss_tag.layer   = lay_q;
    iss_tag.nrn     = nrn_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_run) begin
          state_d = ST_ISSUE;
          lay_d   = 2'd0;
          nrn_d   = '0;
          idx_d   = '0;
          bph_d   = 1'b1;
        end
      end
      ST_ISSUE: begin
        if (bph_q) begin
          bph_d = 1'b0;
          idx_d = '0;
        end else if (iss_tag.last) begin
          bph_d = 1'b1;
          if (nrn_q == nout - NCW'(1)) begin
            state_d = ST_DRAIN;
          end else begin
            nrn_d = nrn_q + NCW'(1);
          end
        end else begin
          idx_d = idx_q + ICW'(1);
        end
      end
      ST_DRAIN: begin
        // The next layer reads what this one wrote, so wait for the last write.
        if (pipe_empty) begin
          if (lay_q == 2'd2) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            lay_d   = lay_q + 2'd1;
            nrn_d   = '0;
            idx_d   = '0;
            bph_d   = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lay_q   <= '0;
      nrn_q   <= '0;
      idx_q   <= '0;
      bph_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      lay_q   <= lay_d;
      nrn_q   <= nrn_d;
      idx_q   <= idx_d;
      bph_q   <= bph_d;
    end
  end

  // Load write ports.
  logic           ld_w, ld_b, ld_x;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;
  always_comb begin
    ld_w = 1'b0;
    ld_b = 1'b0;
    ld_x = accept && (func_e'(func_i) == FUNC_INPUT) && (int'(col_i) < MaxInputs);
    w_waddr = '0;
    b_waddr = '0;
    if (accept && func_e'(func_i) == FUNC_WEIGHT) begin
      priority if (layer_i == 2'd0 && int'(row_i) < MaxHidden && int'(col_i) < MaxInputs)
      begin
        ld_w    = 1'b1;
        w_waddr = WAW'(int'(row_i) * MaxInputs + int'(col_i));
      end else if (layer_i == 2'd1 && int'(row_i) < MaxHidden && int'(col_i) < MaxHidden)
      begin
        ld_w    = 1'b1;
        w_waddr = WAW'(W1Base + int'(row_i) * MaxHidden + int'(col_i));
      end else if (layer_i == 2'd2 && int'(row_i) < MaxOutputs && int'(col_i) < MaxHidden)
      begin
        ld_w    = 1'b1;
        w_waddr = WAW'(W2Base + int'(row_i) * MaxHidden + int'(col_i));
      end else begin
        ld_w = 1'b0;
      end
    end
    if (accept && func_e'(func_i) == FUNC_BIAS) begin
      priority if (layer_i == 2'd0 && int'(row_i) < MaxHidden) begin
        ld_b    = 1'b1;
        b_waddr = BAW'(int'(row_i));
      end else if (layer_i == 2'd1 && int'(row_i) < MaxHidden) begin
        ld_b    = 1'b1;
        b_waddr = BAW'(MaxHidden + int'(row_i));
      end else if (layer_i == 2'd2 && int'(row_i) < MaxOutputs) begin
        ld_b    = 1'b1;
        b_waddr = BAW'(2 * MaxHidden + int'(row_i));
      end else begin
        ld_b = 1'b0;
      end
    end
  end

  // Read addresses for the issued access.
  always_comb begin
    unique case (lay_q)
      2'd0: begin
        w_raddr = WAW'(int'(nrn_q) * MaxInputs + int'(idx_q));
        b_raddr = BAW'(int'(nrn_q));
      end
      2'd1: begin
        w_raddr = WAW'(W1Base + int'(nrn_q) * MaxHidden + int'(idx_q));
        b_raddr = BAW'(MaxHidden + int'(nrn_q));
      end
      default: begin
        w_raddr = WAW'(W2Base + int'(nrn_q) * MaxHidden + int'(idx_q));
        b_raddr = BAW'(2 * MaxHidden + int'(nrn_q));
      end
    endcase
  end

  // Writeback of finished neurons.
  logic signed [DataWidth-1:0] fin_val;
  logic                        h1_we, h2_we;
  logic [DataWidth-1:0]        w_rd, b_rd, x_rd, h1_rd, h2_rd;

  mlp_ram #(.Width(DataWidth), .Depth(WDepth)) u_wram (
    .clk_i, .we_i(ld_w), .waddr_i(w_waddr), .wdata_i(value_i),
    .raddr_i(w_raddr), .rdata_o(w_rd)
  );
  mlp_ram #(.Width(DataWidth), .Depth(BDepth)) u_bram (
    .clk_i, .we_i(ld_b), .waddr_i(b_waddr), .wdata_i(value_i),
    .raddr_i(b_raddr), .rdata_o(b_rd)
  );
  mlp_ram #(.Width(DataWidth), .Depth(MaxInputs)) u_xram (
    .clk_i, .we_i(ld_x), .waddr_i(col_i[IAW-1:0]), .wdata_i(value_i),
    .raddr_i(idx_q[IAW-1:0]), .rdata_o(x_rd)
  );
  mlp_ram #(.Width(DataWidth), .Depth(MaxHidden)) u_h1ram (
    .clk_i, .we_i(h1_we), .waddr_i(f_tag_q.nrn[HAW-1:0]), .wdata_i(fin_val),
    .raddr_i(idx_q[HAW-1:0]), .rdata_o(h1_rd)
  );
  mlp_ram #(.Width(DataWidth), .Depth(MaxHidden)) u_h2ram (
    .clk_i, .we_i(h2_we), .waddr_i(f_tag_q.nrn[HAW-1:0]), .wdata_i(fin_val),
    .raddr_i(idx_q[HAW-1:0]), .rdata_o(h2_rd)
  );

  // Datapath: read, multiply, accumulate, narrow.
  logic signed [DataWidth-1:0] act;
  logic signed [ProdWidth-1:0] prod_q;
  logic signed [AccWidth-1:0]  acc_q, acc_d;
  logic signed [AccWidth:0]    sum;

  always_comb begin
    unique case (s1_tag_q.layer)
      2'd0:    act = x_rd;
      2'd1:    act = h1_rd;
      default: act = h2_rd;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_tag_q.is_bias) begin
      prod_q <= ProdWidth'($signed(b_rd)) <<< FracBits;
    end else begin
      prod_q <= $signed(w_rd) * act;
    end
  end

  assign sum = (AccWidth + 1)'(acc_q) + (AccWidth + 1)'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (s2_v_q) begin
      if (s2_tag_q.is_bias) begin
        acc_d = AccWidth'(prod_q);
      end else if (sum[AccWidth] != sum[AccWidth-1]) begin
        acc_d = sum[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
      end else begin
        acc_d = sum[AccWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      f_v_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      f_v_q  <= s2_v_q & s2_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= iss_tag;
    s2_tag_q <= s1_tag_q;
    f_tag_q  <= s2_tag_q;
  end

  // Floor shift then saturate; ReLU on the hidden layers.
  logic signed [AccWidth-FracBits-1:0] q;
  always_comb begin
    q = acc_q[AccWidth-1:FracBits];
    if (q > (AccWidth-FracBits)'(32767)) begin
      fin_val = 16'sd32767;
    end else if (q < -(AccWidth-FracBits)'(32768)) begin
      fin_val = -16'sd32768;
    end else begin
      fin_val = q[DataWidth-1:0];
    end
    if (f_tag_q.layer != 2'd2 && fin_val < 0) begin
      fin_val = '0;
    end
  end

  assign h1_we = f_v_q && (f_tag_q.layer == 2'd0);
  assign h2_we = f_v_q && (f_tag_q.layer == 2'd1);

  logic emit;
  assign emit = f_v_q && (f_tag_q.layer == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      valid_o <= emit;
      last_o  <= emit && (f_tag_q.nrn == n3 - NCW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      logit_index_o <= f_tag_q.nrn[2:0];
      logit_value_o <= fin_val;
    end
  end

`ifndef ASSERT_OFF
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(f_v_q) && $past(f_tag_q.layer) == 2'd2)
    else $error("result strobe without a finished output neuron");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last marker without a result");
  a_layer_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d == ST_ISSUE) |-> pipe_empty)
    else $error("next layer started before the previous one was written");
  a_no_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !s1_v_q || $past(state_q == ST_ISSUE))
    else $error("access issued while idle");
`endif
endmodule
`default_nettype wire

// File: sv/mlp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mlp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
